// ===== hw/rtl/wtcd_pkg.sv =====
// ----------------------------------------------------------------------------
// wtcd_pkg: shared types and constants of the wheel/tilt crash detector
// Beat payloads, configuration record, mode and sequencer codes, reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package wtcd_pkg;

    // Configuration port
    localparam int ADDR_WIDTH = 5;
    localparam int DATA_WIDTH = 32;

    localparam logic [2:0] REG_DEBOUNCE     = 3'd0;
    localparam logic [2:0] REG_HOLD         = 3'd1;
    localparam logic [2:0] REG_TIMEOUT      = 3'd2;
    localparam logic [2:0] REG_SPEED_LIMIT  = 3'd3;
    localparam logic [2:0] REG_SPEED_FACTOR = 3'd4;

    localparam logic [15:0] DEBOUNCE_RST     = 16'd40;
    localparam logic [15:0] HOLD_RST         = 16'd5000;
    localparam logic [15:0] TIMEOUT_RST      = 16'd10000;
    localparam logic [7:0]  SPEED_LIMIT_RST  = 8'd5;
    // 0.56 m per pulse times 3600
    localparam logic [15:0] SPEED_FACTOR_RST = 16'd2016;

    // Item commands
    localparam logic CMD_PULSE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

    // Divider: one quotient bit per step
    localparam int DIV_STEPS = 16;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        MODE_STOPPED = 2'd0,
        MODE_MOVING  = 2'd1,
        MODE_CRASH   = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PULSE,
        ST_DIVIDE,
        ST_ARM,
        ST_HOLD,
        ST_STOP,
        ST_DONE
    } seq_state_t;

    typedef struct packed {
        logic        command;
        logic [31:0] now_ms;
        logic        tilt1_level;
        logic        tilt2_level;
    } item_t;

    typedef struct packed {
        logic [1:0]  bike_state;
        logic [15:0] speed_kmh;
    } result_t;

    typedef struct packed {
        logic [15:0] debounce_ms;
        logic [15:0] accident_hold_ms;
        logic [15:0] stop_timeout_ms;
        logic [7:0]  accident_speed_kmh;
        logic [15:0] speed_factor;
    } cfg_t;

    typedef struct packed {
        logic        done;
        logic [15:0] quotient;
    } div_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/wtcd_regs.sv =====
// ----------------------------------------------------------------------------
// wtcd_regs: configuration register file
// APB-style slave holding the five detector settings; zero wait states.
// ----------------------------------------------------------------------------
`default_nettype none

module wtcd_regs
    import wtcd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [ADDR_WIDTH-1:0] paddr,
    input  wire logic [DATA_WIDTH-1:0] pwdata,
    output logic      [DATA_WIDTH-1:0] prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    cfg_t       cfg_reg;
    logic [2:0] index;
    logic       write_en;

    assign index    = paddr[ADDR_WIDTH-1:2];
    assign pready   = 1'b1;
    assign write_en = psel && penable && pwrite && pready;
    assign cfg      = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms        <= DEBOUNCE_RST;
            cfg_reg.accident_hold_ms   <= HOLD_RST;
            cfg_reg.stop_timeout_ms    <= TIMEOUT_RST;
            cfg_reg.accident_speed_kmh <= SPEED_LIMIT_RST;
            cfg_reg.speed_factor       <= SPEED_FACTOR_RST;
        end
        else if (write_en)
        begin
            unique case (index)
                REG_DEBOUNCE:     cfg_reg.debounce_ms        <= pwdata[15:0];
                REG_HOLD:         cfg_reg.accident_hold_ms   <= pwdata[15:0];
                REG_TIMEOUT:      cfg_reg.stop_timeout_ms    <= pwdata[15:0];
                REG_SPEED_LIMIT:  cfg_reg.accident_speed_kmh <= pwdata[7:0];
                REG_SPEED_FACTOR: cfg_reg.speed_factor       <= pwdata[15:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            REG_DEBOUNCE:     prdata = DATA_WIDTH'(cfg_reg.debounce_ms);
            REG_HOLD:         prdata = DATA_WIDTH'(cfg_reg.accident_hold_ms);
            REG_TIMEOUT:      prdata = DATA_WIDTH'(cfg_reg.stop_timeout_ms);
            REG_SPEED_LIMIT:  prdata = DATA_WIDTH'(cfg_reg.accident_speed_kmh);
            REG_SPEED_FACTOR: prdata = DATA_WIDTH'(cfg_reg.speed_factor);
            default:          prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/wtcd_divider.sv =====
// ----------------------------------------------------------------------------
// wtcd_divider: serial restoring divider for the speed quotient
// 16-bit dividend over a time-wide divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module wtcd_divider
    import wtcd_pkg::*;
#(
    parameter int TIME_WIDTH = 32
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [15:0]           dividend,
    input  wire logic [TIME_WIDTH-1:0] divisor,
    output div_status_t                status
);

    logic [16:0]          rem_reg, rem_next;
    logic [15:0]          quo_reg, quo_next;
    logic [15:0]          div_reg;
    logic                 big_reg;
    logic [DIV_CNT_W-1:0] count_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic                 hi_nz;
    logic [16:0]          shifted;
    logic                 ge;

    // A divisor above 16 bits always gives a zero quotient
    if (TIME_WIDTH > 16)
    begin : g_wide
        assign hi_nz = |divisor[TIME_WIDTH-1:16];
    end
    else
    begin : g_narrow
        assign hi_nz = 1'b0;
    end

    // A zero divisor never fails the compare, so the quotient saturates on its own
    always_comb
    begin
        shifted  = {rem_reg[15:0], quo_reg[15]};
        ge       = !big_reg && (shifted >= {1'b0, div_reg});
        rem_next = ge ? (shifted - {1'b0, div_reg}) : shifted;
        quo_next = {quo_reg[14:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg + 1'b1;
                if (count_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor[15:0];
            big_reg <= hi_nz;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign status.done     = done_reg;
    assign status.quotient = quo_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/wheel_tilt_crash_detector_unit.sv =====
// ----------------------------------------------------------------------------
// wheel_tilt_crash_detector_unit: wheel pulse and tilt crash detector
//
// Input channel (item_valid/item_stall/item) carries wheel pulse beats and
// evaluate beats with two tilt levels. Output channel (result_valid/
// result_stall/result) returns one beat per item: bike state after the item
// and the speed computed by an evaluate beat (zero for a pulse).
// Steps: a pulse passes a debounce step and then the final step; an evaluate
// runs the serial divider, one quotient bit per cycle, then the arm step and,
// in moving mode, the hold check and, unless that crashes, the stop check. One
// item is in work at a time; item_stall stays high from accept until the
// result is loaded into the output register, and no new item is taken until then.
// A finished result waits in the output register while the next item is
// accepted; if the receiver stalls, that next item holds in its final step
// until the register frees up.
// Reset clears the mode, pulse times, arm flag and output valid, and loads
// the configuration defaults. The user must see that the APB port writes
// settings only while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module wheel_tilt_crash_detector_unit
    import wtcd_pkg::*;
#(
    parameter int TIME_WIDTH = 32
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    output logic                       item_stall,
    input  wire item_t                 item,
    output logic                       result_valid,
    input  wire logic                  result_stall,
    output result_t                    result,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [ADDR_WIDTH-1:0] paddr,
    input  wire logic [DATA_WIDTH-1:0] pwdata,
    output logic      [DATA_WIDTH-1:0] prdata,
    output logic                       pready
);

    cfg_t        cfg;
    div_status_t div_status;

    seq_state_t  state_reg, state_next;
    mode_t       mode_reg, mode_next;
    logic        armed_reg, armed_next;
    logic [TIME_WIDTH-1:0] last_reg, last_next;
    logic [TIME_WIDTH-1:0] prev_reg, prev_next;
    logic [TIME_WIDTH-1:0] arm_time_reg, arm_time_next;

    logic                  cmd_reg;
    logic [TIME_WIDTH-1:0] now_reg;
    logic                  tilt1_reg, tilt2_reg;
    logic [15:0]           speed_reg, speed_next;

    logic                  result_valid_reg, result_valid_next;
    result_t               result_reg, result_next;

    logic                  accept;
    logic                  div_start;
    logic [TIME_WIDTH-1:0] interval;
    logic [TIME_WIDTH-1:0] cmp_base;
    logic [15:0]           cmp_limit;
    logic [TIME_WIDTH-1:0] cmp_diff;
    logic                  cmp_gt;
    logic                  tilted, upright;

    wtcd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    wtcd_divider #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (cfg.speed_factor),
        .divisor  (interval),
        .status   (div_status)
    );

    assign item_stall   = (state_reg != ST_IDLE);
    assign accept       = item_valid && !item_stall;
    assign div_start    = accept && (item.command == CMD_EVAL);
    assign interval     = last_reg - prev_reg;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign tilted  = !tilt1_reg || !tilt2_reg;
    assign upright = tilt1_reg && tilt2_reg;

    // Shared wrapping time compare: (now - base) > limit
    always_comb
    begin
        unique case (state_reg)
            ST_HOLD:
            begin
                cmp_base  = arm_time_reg;
                cmp_limit = cfg.accident_hold_ms;
            end
            ST_STOP:
            begin
                cmp_base  = last_reg;
                cmp_limit = cfg.stop_timeout_ms;
            end
            default:
            begin
                cmp_base  = last_reg;
                cmp_limit = cfg.debounce_ms;
            end
        endcase
        cmp_diff = now_reg - cmp_base;
        cmp_gt   = cmp_diff > TIME_WIDTH'(cmp_limit);
    end

    always_comb
    begin
        state_next        = state_reg;
        mode_next         = mode_reg;
        armed_next        = armed_reg;
        last_next         = last_reg;
        prev_next         = prev_reg;
        arm_time_next     = arm_time_reg;
        speed_next        = speed_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    speed_next = '0;
                    state_next = (item.command == CMD_EVAL) ? ST_DIVIDE : ST_PULSE;
                end
            end
            ST_PULSE:
            begin
                if (cmp_gt)
                begin
                    if (mode_reg == MODE_STOPPED)
                    begin
                        mode_next = MODE_MOVING;
                    end
                    prev_next = last_reg;
                    last_next = now_reg;
                end
                state_next = ST_DONE;
            end
            ST_DIVIDE:
            begin
                if (div_status.done)
                begin
                    speed_next = div_status.quotient;
                    state_next = ST_ARM;
                end
            end
            ST_ARM:
            begin
                priority case (mode_reg)
                    MODE_MOVING:
                    begin
                        if (tilted && !armed_reg
                            && (speed_reg > 16'(cfg.accident_speed_kmh)))
                        begin
                            armed_next    = 1'b1;
                            arm_time_next = now_reg;
                        end
                        else if (armed_reg && upright)
                        begin
                            armed_next = 1'b0;
                        end
                        state_next = ST_HOLD;
                    end
                    MODE_CRASH:
                    begin
                        if (upright)
                        begin
                            mode_next = MODE_STOPPED;
                        end
                        state_next = ST_DONE;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_HOLD:
            begin
                if (armed_reg && cmp_gt)
                begin
                    mode_next  = MODE_CRASH;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_STOP;
                end
            end
            ST_STOP:
            begin
                if (cmp_gt)
                begin
                    mode_next  = MODE_STOPPED;
                    armed_next = 1'b0;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // Hold until the output register is free
                if (!result_valid_reg || !result_stall)
                begin
                    result_next.bike_state = mode_reg;
                    result_next.speed_kmh  = speed_reg;
                    result_valid_next      = 1'b1;
                    state_next             = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            mode_reg         <= MODE_STOPPED;
            armed_reg        <= 1'b0;
            last_reg         <= '0;
            prev_reg         <= '0;
            arm_time_reg     <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            mode_reg         <= mode_next;
            armed_reg        <= armed_next;
            last_reg         <= last_next;
            prev_reg         <= prev_next;
            arm_time_reg     <= arm_time_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= item.command;
            now_reg   <= TIME_WIDTH'(item.now_ms);
            tilt1_reg <= item.tilt1_level;
            tilt2_reg <= item.tilt2_level;
        end
        speed_reg  <= speed_next;
        result_reg <= result_next;
    end

    // Checks

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg == ST_DONE))
        else $error("result beat raised outside the final step");

    a_div_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        div_status.done |-> (state_reg == ST_DIVIDE))
        else $error("divider finished while the sequencer was not waiting");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != ST_IDLE))
        else $error("accepted item did not start the sequencer");

    a_pulse_path: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PULSE) |-> (cmd_reg == CMD_PULSE) && (speed_reg == 16'd0))
        else $error("pulse step entered for an evaluate item");

endmodule

`default_nettype wire

// ===== tb/wheel_tilt_crash_detector_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wheel_tilt_crash_detector_unit_tb: self-checking bench of the crash detector
// Drives pulse and evaluate beats with random gaps and random output stalls,
// predicts bike state and speed for every accepted beat, and compares each
// result beat in order. Settings are changed over APB between drained phases.
// ----------------------------------------------------------------------------

module wheel_tilt_crash_detector_unit_tb;

    import wtcd_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_CYCLES = 32;
    localparam int unsigned PHASE_BEATS  = 150;

    localparam cfg_t CFG_DEFAULT = {DEBOUNCE_RST, HOLD_RST, TIMEOUT_RST,
                                    SPEED_LIMIT_RST, SPEED_FACTOR_RST};
    localparam cfg_t CFG_MAX     = {16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF};
    localparam cfg_t CFG_MIN     = {16'd0, 16'd0, 16'd0, 8'd0, 16'd0};

    logic                  clk;
    logic                  rst_n        = 1'b0;
    logic                  item_valid   = 1'b0;
    logic                  item_stall;
    item_t                 item         = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    result_t               result;
    logic                  psel         = 1'b0;
    logic                  penable      = 1'b0;
    logic                  pwrite       = 1'b0;
    logic [ADDR_WIDTH-1:0] paddr        = '0;
    logic [DATA_WIDTH-1:0] pwdata       = '0;
    logic [DATA_WIDTH-1:0] prdata;
    logic                  pready;

    wheel_tilt_crash_detector_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Predicted detector state and the settings it runs with
    cfg_t        shadow     = CFG_DEFAULT;
    mode_t       cur_mode   = MODE_STOPPED;
    logic [31:0] pulse_last = '0;
    logic [31:0] pulse_prev = '0;
    logic        armed      = 1'b0;
    logic [31:0] armed_at   = '0;

    result_t     expected_q[$];
    result_t     want;
    int unsigned sent_count      = 0;
    int unsigned done_count      = 0;
    int unsigned mismatches      = 0;
    int unsigned hold_off_cycles = 0;
    int unsigned cycle_count     = 0;
    logic        send_gaps_on    = 1'b1;
    logic        recv_gaps_on    = 1'b1;
    logic [31:0] clock_ms        = '0;
    logic        tilt_run        = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("wheel_tilt_crash_detector_unit: mismatch");
        $finish;
    end

    function automatic result_t predict_beat(input item_t it);
        result_t     r;
        logic [31:0] span;
        logic [31:0] quot;
        logic        upright;
        r.speed_kmh = '0;
        if (it.command == CMD_PULSE)
        begin
            span = it.now_ms - pulse_last;
            if (span > shadow.debounce_ms)
            begin
                if (cur_mode == MODE_STOPPED)
                    cur_mode = MODE_MOVING;
                pulse_prev = pulse_last;
                pulse_last = it.now_ms;
            end
        end
        else
        begin
            upright = it.tilt1_level && it.tilt2_level;
            span    = pulse_last - pulse_prev;
            if (span == 32'd0)
                r.speed_kmh = 16'hFFFF;
            else
            begin
                quot        = {16'd0, shadow.speed_factor} / span;
                r.speed_kmh = (quot > 32'h0000_FFFF) ? 16'hFFFF : quot[15:0];
            end
            if (cur_mode == MODE_MOVING)
            begin
                if (!upright && !armed && r.speed_kmh > shadow.accident_speed_kmh)
                begin
                    armed    = 1'b1;
                    armed_at = it.now_ms;
                end
                else if (armed && upright)
                    armed = 1'b0;
                span = it.now_ms - armed_at;
                if (armed && span > shadow.accident_hold_ms)
                    cur_mode = MODE_CRASH;
                else
                begin
                    span = it.now_ms - pulse_last;
                    if (span > shadow.stop_timeout_ms)
                    begin
                        cur_mode = MODE_STOPPED;
                        armed    = 1'b0;
                    end
                end
            end
            else if (cur_mode == MODE_CRASH)
            begin
                if (upright)
                    cur_mode = MODE_STOPPED;
            end
        end
        r.bike_state = cur_mode;
        return r;
    endfunction

    // Check result beats in order, then record the prediction for a new item beat
    always @(posedge clk)
    begin
        if (result_valid && !result_stall)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t: result beat with none expected: state %0d speed %0d",
                         $time, result.bike_state, result.speed_kmh);
                mismatches++;
            end
            else
            begin
                want = expected_q.pop_front();
                done_count++;
                if (result.bike_state !== want.bike_state)
                begin
                    $display("%0t: bike_state expected %0d actual %0d",
                             $time, want.bike_state, result.bike_state);
                    mismatches++;
                end
                if (result.speed_kmh !== want.speed_kmh)
                begin
                    $display("%0t: speed_kmh expected %0d actual %0d",
                             $time, want.speed_kmh, result.speed_kmh);
                    mismatches++;
                end
            end
        end
        if (item_valid && !item_stall)
            expected_q.push_back(predict_beat(item));
    end

    // Output side: stall a random number of cycles before each beat
    initial
    begin
        int unsigned n;
        forever
        begin
            n = recv_gaps_on ? $urandom_range(0, 15) : 0;
            if (hold_off_cycles != 0)
            begin
                n               = hold_off_cycles;
                hold_off_cycles = 0;
            end
            if (n != 0)
            begin
                result_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            result_stall <= 1'b0;
            do @(posedge clk); while (!result_valid);
        end
    end

    task automatic send_beat(input logic cmd, input logic [31:0] t,
                             input logic t1, input logic t2);
        int unsigned gap;
        gap = send_gaps_on ? $urandom_range(0, 15) : 0;
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        clock_ms    = t;
        item_valid <= 1'b1;
        item       <= {cmd, t, t1, t2};
        do @(posedge clk); while (item_stall);
        sent_count++;
    endtask

    task automatic wait_idle();
        item_valid <= 1'b0;
        while (done_count != sent_count) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_config(input cfg_t c);
        wait_idle();
        write_reg(REG_DEBOUNCE, c.debounce_ms);
        write_reg(REG_HOLD, c.accident_hold_ms);
        write_reg(REG_TIMEOUT, c.stop_timeout_ms);
        write_reg(REG_SPEED_LIMIT, {8'd0, c.accident_speed_kmh});
        write_reg(REG_SPEED_FACTOR, c.speed_factor);
        shadow = c;
    endtask

    // Advance time by a step scaled to the current settings, then send one beat
    task automatic random_beat();
        int unsigned pick;
        logic [31:0] step;
        logic [1:0]  tilts;
        logic        cmd;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            step = shadow.debounce_ms + $urandom_range(0, 1);
        else if (pick < 50)
            step = $urandom_range(0, shadow.debounce_ms + 40);
        else if (pick < 72)
            step = $urandom_range(0, shadow.accident_hold_ms + 50);
        else if (pick < 90)
            step = $urandom_range(0, shadow.stop_timeout_ms + 100);
        else if (pick < 96)
            step = shadow.stop_timeout_ms + $urandom_range(0, 2);
        else
            step = $urandom;
        cmd = ($urandom_range(0, 99) < 40) ? CMD_PULSE : CMD_EVAL;
        if ($urandom_range(0, 9) == 0)
            tilt_run = ~tilt_run;
        // hold a tilted stretch so the arm timer can run out
        tilts = tilt_run ? $urandom_range(0, 2) : 2'b11;
        if ($urandom_range(0, 19) == 0)
            tilts = $urandom_range(0, 3);
        send_beat(cmd, clock_ms + step, tilts[1], tilts[0]);
    endtask

    task automatic test_pulse_and_crash();
        send_beat(CMD_EVAL,  32'd0,     1'b1, 1'b1);  // stopped, equal pulse times
        send_beat(CMD_PULSE, 32'd0,     1'b0, 1'b1);  // inside debounce: drop
        send_beat(CMD_PULSE, 32'd40,    1'b1, 1'b0);  // exactly debounce: drop
        send_beat(CMD_PULSE, 32'd41,    1'b1, 1'b1);
        send_beat(CMD_EVAL,  32'd60,    1'b1, 1'b1);
        send_beat(CMD_EVAL,  32'd70,    1'b0, 1'b1);  // arm
        send_beat(CMD_PULSE, 32'd400,   1'b0, 1'b0);
        send_beat(CMD_EVAL,  32'd5071,  1'b1, 1'b0);  // hold just exceeded
        send_beat(CMD_EVAL,  32'd5073,  1'b1, 1'b1);  // upright leaves crash
        send_beat(CMD_PULSE, 32'd5500,  1'b1, 1'b1);
        send_beat(CMD_EVAL,  32'd5501,  1'b0, 1'b0);  // stale arm flag crashes at once
        send_beat(CMD_EVAL,  32'd5502,  1'b1, 1'b1);
        send_beat(CMD_PULSE, 32'd5600,  1'b1, 1'b1);
        send_beat(CMD_EVAL,  32'd15601, 1'b1, 1'b1);  // no pulse for too long
    endtask

    task automatic test_time_wrap();
        send_beat(CMD_PULSE, 32'hFFFF_FFF0, 1'b1, 1'b1);
        send_beat(CMD_PULSE, 32'h0000_0018, 1'b1, 1'b1);
        send_beat(CMD_PULSE, 32'h0000_0019, 1'b1, 1'b1);
        send_beat(CMD_EVAL,  32'h0000_0019, 1'b0, 1'b1);
    endtask

    task automatic test_config_extremes();
        cfg_t c;
        apply_config(CFG_MAX);
        send_beat(CMD_PULSE, clock_ms + 32'd65535, 1'b1, 1'b1);
        send_beat(CMD_PULSE, clock_ms + 32'd1,     1'b1, 1'b1);
        send_beat(CMD_EVAL,  clock_ms,             1'b0, 1'b1);
        apply_config(CFG_MIN);
        send_beat(CMD_PULSE, clock_ms + 32'd1,     1'b1, 1'b1);
        send_beat(CMD_EVAL,  clock_ms,             1'b1, 1'b0);  // zero speed factor
        c              = CFG_MIN;
        c.speed_factor = 16'd1;
        apply_config(c);
        send_beat(CMD_EVAL,  clock_ms,             1'b0, 1'b0);
        send_beat(CMD_EVAL,  clock_ms + 32'd1,     1'b0, 1'b0);
        send_beat(CMD_PULSE, clock_ms + 32'd1,     1'b0, 1'b0);  // pulse in crash
        c.speed_factor = 16'hFFFF;
        apply_config(c);
        send_beat(CMD_EVAL,  clock_ms,             1'b1, 1'b1);
    endtask

    task automatic test_result_backpressure();
        apply_config(CFG_DEFAULT);
        hold_off_cycles = 300;
        send_gaps_on    = 1'b0;
        repeat (12) random_beat();
        send_gaps_on    = 1'b1;
    endtask

    task automatic test_random_traffic();
        cfg_t c;
        for (int p = 0; p < 10; p++)
        begin
            if (p == 2)
                c = CFG_MAX;
            else if (p == 5)
            begin
                c              = CFG_MIN;
                c.speed_factor = 16'd1;
            end
            else
            begin
                c.debounce_ms = ($urandom_range(0, 3) == 0) ?
                                $urandom_range(0, 65535) : $urandom_range(0, 60);
                c.accident_hold_ms = ($urandom_range(0, 3) == 0) ?
                                     $urandom_range(0, 65535) : $urandom_range(0, 400);
                c.stop_timeout_ms = ($urandom_range(0, 3) == 0) ?
                                    $urandom_range(0, 65535) : $urandom_range(0, 2000);
                c.accident_speed_kmh = ($urandom_range(0, 3) == 0) ?
                                       $urandom_range(0, 255) : $urandom_range(0, 20);
                c.speed_factor = $urandom_range(1, 65535);
            end
            apply_config(c);
            send_gaps_on = (p != 3 && p != 7);
            recv_gaps_on = (p != 3 && p != 7);
            repeat (PHASE_BEATS) random_beat();
        end
        send_gaps_on = 1'b1;
        recv_gaps_on = 1'b1;
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_pulse_and_crash();
        test_time_wrap();
        test_config_extremes();
        test_result_backpressure();
        test_random_traffic();

        wait_idle();
        if (expected_q.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, expected_q.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("wheel_tilt_crash_detector_unit: match");
        else
            $display("wheel_tilt_crash_detector_unit: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/wtcd_pkg.sv
hw/rtl/wtcd_regs.sv
hw/rtl/wtcd_divider.sv
hw/rtl/wheel_tilt_crash_detector_unit.sv
tb/wheel_tilt_crash_detector_unit_tb.sv
